/* src/sofdf_pkg.sv */
// Shared types and constants of the frame deframer.
`timescale 1ns / 1ps

package sofdf_pkg;

   localparam logic [7:0] START_BYTE_RESET = 8'hFE;
   localparam int         QUEUE_DEPTH      = 4;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_LEN,
      PH_CMD0,
      PH_CMD1,
      PH_DATA,
      PH_FCS
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER,
      KIND_PAYLOAD,
      KIND_END
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] command_word;
      logic [7:0]  payload_length;
      logic [7:0]  payload_byte;
      logic [7:0]  byte_index;
      logic        check_ok;
   } rsp_item_type;

   // Write side of the queue, driven by the front end.
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } push_type;

   // Head of the queue as seen by the back end.
   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } head_type;

endpackage

/* src/sofdf_req_if.sv */
// Input channel carrying one received byte per transaction.
`timescale 1ns / 1ps

interface sofdf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

/* src/sofdf_rsp_if.sv */
// Result channel carrying one decoded frame event per transaction.
`timescale 1ns / 1ps

interface sofdf_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] command_word;
   logic [7:0]  payload_length;
   logic [7:0]  payload_byte;
   logic [7:0]  byte_index;
   logic        check_ok;

   modport source (output valid, output kind, output command_word, output payload_length,
                   output payload_byte, output byte_index, output check_ok, input ready);
   modport sink   (input valid, input kind, input command_word, input payload_length,
                   input payload_byte, input byte_index, input check_ok, output ready);
endinterface

/* src/sofdf_front.sv */
// Front end: byte parser that classifies each received byte and queues results.
`timescale 1ns / 1ps

module sofdf_front
   import sofdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   sofdf_req_if.sink    req,
   input  logic         csr_write_en,
   input  logic [7:0]   csr_write_data,
   input  logic         queue_full,
   output push_type     push
);

   phase_type   phase_ff, phase_in;
   logic [7:0]  start_byte_ff, start_byte_in;
   logic [7:0]  frame_length_ff, frame_length_in;
   logic [7:0]  payload_count_ff, payload_count_in;
   logic [7:0]  running_check_ff, running_check_in;
   logic [7:0]  command_high_ff, command_high_in;
   logic        accept;
   logic [7:0]  rx;
   logic [7:0]  count_next;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign rx        = req.rx_byte;
   assign count_next = payload_count_ff + 8'd1;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         start_byte_ff    <= START_BYTE_RESET;
         frame_length_ff  <= '0;
         payload_count_ff <= '0;
         running_check_ff <= '0;
         command_high_ff  <= '0;
      end else begin
         phase_ff         <= phase_in;
         start_byte_ff    <= start_byte_in;
         frame_length_ff  <= frame_length_in;
         payload_count_ff <= payload_count_in;
         running_check_ff <= running_check_in;
         command_high_ff  <= command_high_in;
      end
   end

   always_comb begin
      phase_in         = phase_ff;
      start_byte_in    = csr_write_en ? csr_write_data : start_byte_ff;
      frame_length_in  = frame_length_ff;
      payload_count_in = payload_count_ff;
      running_check_in = running_check_ff;
      command_high_in  = command_high_ff;

      push                     = '0;
      push.item.kind           = KIND_HEADER;
      push.item.payload_length = frame_length_ff;

      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (rx == start_byte_ff) begin
                  phase_in = PH_LEN;
               end
            end
            PH_LEN: begin
               frame_length_in  = rx;
               running_check_in = rx;
               payload_count_in = '0;
               phase_in         = PH_CMD0;
            end
            PH_CMD0: begin
               command_high_in  = rx;
               running_check_in = running_check_ff ^ rx;
               phase_in         = PH_CMD1;
            end
            PH_CMD1: begin
               running_check_in       = running_check_ff ^ rx;
               push.valid             = 1'b1;
               push.item.kind         = KIND_HEADER;
               push.item.command_word = {command_high_ff, rx};
               phase_in = (frame_length_ff != 8'd0) ? PH_DATA : PH_FCS;
            end
            PH_DATA: begin
               running_check_in       = running_check_ff ^ rx;
               push.valid             = 1'b1;
               push.item.kind         = KIND_PAYLOAD;
               push.item.payload_byte = rx;
               push.item.byte_index   = payload_count_ff;
               payload_count_in       = count_next;
               if (count_next == frame_length_ff) begin
                  phase_in = PH_FCS;
               end
            end
            PH_FCS: begin
               push.valid         = 1'b1;
               push.item.kind     = KIND_END;
               push.item.check_ok = (rx == running_check_ff);
               phase_in           = PH_HUNT;
            end
            default: begin
               phase_in = PH_HUNT;
            end
         endcase
      end
   end

   // The payload phase is only entered with a non-zero length and left on the last byte.
   a_data_count_in_range: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_DATA) |-> (payload_count_ff < frame_length_ff))
      else $error("payload count reached frame length while still in payload phase");

   a_fcs_returns_to_hunt: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_FCS) |=> (phase_ff == PH_HUNT))
      else $error("parser did not resume hunting after the check byte");

endmodule

/* src/sofdf_queue.sv */
// Short result queue that decouples the parser from the output stage.
`timescale 1ns / 1ps

module sofdf_queue
   import sofdf_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic     clock,
   input  logic     reset,
   input  push_type push,
   input  logic     pop,
   output head_type head,
   output logic     full
);

   localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int CntW = $clog2(QueueDepth + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QueueDepth - 1);
   localparam logic [CntW-1:0] DepthCount = CntW'(QueueDepth);

   rsp_item_type    slot_ff [QueueDepth];
   logic [PtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            do_push, do_pop;

   assign full      = (count_ff == DepthCount);
   assign head.valid = (count_ff != '0);
   assign head.item  = slot_ff[rd_ptr_ff];
   assign do_push   = push.valid && !full;
   assign do_pop    = pop && head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      priority if (do_push && !do_pop) begin
         count_in = count_ff + CntW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CntW'(1);
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push.item;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCount)
      else $error("queue occupancy exceeds its depth");

   // The front end must hold off while full, otherwise a result would be lost.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push.valid |-> !full)
      else $error("result pushed into a full queue");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head.valid)
      else $error("result popped from an empty queue");

endmodule

/* src/sofdf_back.sv */
// Back end: output register that presents queued results on the result channel.
`timescale 1ns / 1ps

module sofdf_back
   import sofdf_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  head_type     head,
   output logic         pop,
   sofdf_rsp_if.source  rsp
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;

   // The register is refilled whenever it is empty or its transaction completes.
   assign pop = head.valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      priority if (pop) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = head.item;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.kind           = rsp_item_ff.kind;
   assign rsp.command_word   = rsp_item_ff.command_word;
   assign rsp.payload_length = rsp_item_ff.payload_length;
   assign rsp.payload_byte   = rsp_item_ff.payload_byte;
   assign rsp.byte_index     = rsp_item_ff.byte_index;
   assign rsp.check_ok       = rsp_item_ff.check_ok;

endmodule

/* src/sof_len_cmd_xor_frame_deframer_core.sv */
// Top level of the start/length/command/XOR-check frame deframer.
//
//   Channel   Direction  Carries
//   req       in         rx_byte, one received byte per transaction
//   rsp       out        kind, command_word, payload_length, payload_byte,
//                        byte_index, check_ok
//   csr       in         start_byte write (csr_write_en, csr_write_data)
//
// One byte is accepted per cycle while the queue is not full; a result is registered
// twice on its way out (parser into the queue, queue into the output register).
// Reset clears the parser to hunting and restores the start byte to 0xFE.
// A stalled result channel fills the queue; req.ready falls only when it is full.
`timescale 1ns / 1ps

module sof_len_cmd_xor_frame_deframer_core
   import sofdf_pkg::*;
#(
   parameter int QueueDepth = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   sofdf_req_if.sink    req,
   sofdf_rsp_if.source  rsp,
   input  logic         csr_write_en,
   input  logic [7:0]   csr_write_data
);

   push_type push;
   head_type head;
   logic     pop;
   logic     queue_full;

   sofdf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req            (req),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .push           (push)
   );

   sofdf_queue #(
      .QueueDepth (QueueDepth)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .head  (head),
      .full  (queue_full)
   );

   sofdf_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule
